/* sv/rrle_pkg.sv */
// Package for the raster RLE byte decoder: shared types, codes and constants.
// Used by every module of the block except the checker; depends on nothing.
package rrle_pkg;

  // Escape byte that opens a run or a literal-0x80 pair
  localparam logic [7:0] EscByte = 8'h80;
  // Narrowest supported row width
  localparam logic [15:0] MinWidth = 16'd8;
  // Depth of the command queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);

  // Configuration register indexes (byte address = 4 * index)
  localparam logic RegRowWidth = 1'b0;
  localparam logic RegImageHeight = 1'b1;

  // Escape parser phase, one-hot
  typedef enum logic [2:0] {
    PhPlain = 3'b001,
    PhCount = 3'b010,
    PhValue = 3'b100
  } phase_e;

  // Run command from the parser: value repeated cnt_m1 + 1 times
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] cnt_m1;
  } cmd_t;

  // Image geometry as written by software
  typedef struct packed {
    logic [15:0] row_width;
    logic [15:0] image_height;
  } cfg_t;

  // One output segment
  typedef struct packed {
    logic        last;
    logic        image_end;
    logic        row_end;
    logic [15:0] start_column;
    logic [15:0] row_index;
    logic [8:0]  run_length;
    logic [7:0]  pixel_value;
  } seg_t;

endpackage

/* sv/rrle_front.sv */
// Front end of the raster RLE decoder: escape parsing of the byte stream.
// Turns plain bytes and escape sequences into run commands. Uses rrle_pkg.
module rrle_front import rrle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       push_o,
  output cmd_t       push_cmd_o,
  input  logic       full_i
);

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       accept;

  // Take a word only when the queue has room for a possible command
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // Escape sequence decode
  always_comb begin
    phase_d    = phase_q;
    held_d     = held_q;
    push_o     = 1'b0;
    push_cmd_o = '{value: in_byte_i, cnt_m1: 8'd0};
    if (accept) begin
      unique case (phase_q)
        PhCount: begin
          if (in_byte_i == 8'd0) begin
            push_o     = 1'b1;
            push_cmd_o = '{value: EscByte, cnt_m1: 8'd0};
            phase_d    = PhPlain;
          end else begin
            held_d  = in_byte_i;
            phase_d = PhValue;
          end
        end
        PhValue: begin
          push_o     = 1'b1;
          push_cmd_o = '{value: in_byte_i, cnt_m1: held_q};
          phase_d    = PhPlain;
        end
        default: begin
          if (in_byte_i == EscByte) begin
            phase_d = PhCount;
          end else begin
            push_o  = 1'b1;
            phase_d = PhPlain;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhPlain;
      held_q  <= 8'd0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

/* sv/rrle_queue.sv */
// Command queue between the parser and the run expander.
// Small register-based FIFO of run commands. Uses rrle_pkg.
module rrle_queue import rrle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t pop_cmd_o
);

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q;
  logic                 do_push, do_pop;

  assign full_o    = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* sv/rrle_back.sv */
// Back end of the raster RLE decoder: expands run commands into row segments.
// One step per cycle unless the stream output register stalls. Uses rrle_pkg.
module rrle_back import rrle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output seg_t out_seg_o
);

  logic [7:0]  value_q, value_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [16:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic        done_q, done_d;
  logic        ovalid_q, ovalid_d;
  seg_t        seg_q, seg_d;

  logic [15:0] w16, h16, row_inc;
  logic [16:0] w17, padded, avail;
  logic [8:0]  take, cnt_rem;
  logic        seg_end, seg_img, slot_free;

  // Effective geometry
  assign w16     = (cfg_i.row_width < MinWidth) ? MinWidth : cfg_i.row_width;
  assign h16     = (cfg_i.image_height == 16'd0) ? 16'd1 : cfg_i.image_height;
  assign w17     = {1'b0, w16};
  assign padded  = w17 + {16'd0, w16[0]};
  assign row_inc = row_q + 16'd1;

  // Segment arithmetic for the current column
  assign avail   = w17 - col_q;
  assign seg_end = ({8'd0, cnt_q} >= avail);
  assign take    = seg_end ? avail[8:0] : cnt_q;
  assign cnt_rem = cnt_q - take;
  assign seg_img = seg_end && (row_q == h16 - 16'd1);

  assign slot_free   = !ovalid_q || out_ready_i;
  assign out_valid_o = ovalid_q;
  assign out_seg_o   = seg_q;

  // Expansion loop, one step per cycle; an emit step waits for a free output slot
  always_comb begin
    value_d  = value_q;
    cnt_d    = cnt_q;
    col_d    = col_q;
    row_d    = row_q;
    done_d   = done_q;
    seg_d    = seg_q;
    ovalid_d = ovalid_q && !out_ready_i;
    pop_o    = 1'b0;
    priority if (cnt_q == 9'd0) begin
      // Fetch the next run; once the image is done, runs are dropped
      pop_o = cmd_valid_i;
      if (cmd_valid_i && !done_q) begin
        value_d = cmd_i.value;
        cnt_d   = {1'b0, cmd_i.cnt_m1} + 9'd1;
      end
    end else if (done_q || row_q >= h16) begin
      done_d = 1'b1;
      cnt_d  = 9'd0;
    end else if (col_q >= padded) begin
      // Width shrank under the column: close the row
      col_d = 17'd0;
      row_d = row_inc;
      if (row_inc >= h16) begin
        done_d = 1'b1;
      end
    end else if (col_q >= w17) begin
      // Pad position of an odd-width row uses one copy
      cnt_d = cnt_q - 9'd1;
      col_d = 17'd0;
      row_d = row_inc;
      if (row_inc >= h16) begin
        done_d = 1'b1;
      end
    end else if (slot_free) begin
      ovalid_d           = 1'b1;
      seg_d.pixel_value  = value_q;
      seg_d.run_length   = take;
      seg_d.row_index    = row_q;
      seg_d.start_column = col_q[15:0];
      seg_d.row_end      = seg_end;
      seg_d.image_end    = seg_img;
      seg_d.last         = (cnt_rem == 9'd0) || seg_img ||
                           (seg_end && (padded != w17) && (cnt_rem == 9'd1));
      col_d = col_q + {8'd0, take};
      cnt_d = cnt_rem;
      if (seg_img) begin
        done_d = 1'b1;
        cnt_d  = 9'd0;
      end else if (seg_end && (padded == w17)) begin
        col_d = 17'd0;
        row_d = row_inc;
      end
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 9'd0;
      col_q    <= 17'd0;
      row_q    <= 16'd0;
      done_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      col_q    <= col_d;
      row_q    <= row_d;
      done_q   <= done_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    seg_q   <= seg_d;
  end

endmodule

/* sv/raster_rle_byte_decoder.sv */
// Raster RLE byte decoder, 8-bit pixels: top level with the register port.
// Instantiates rrle_front, rrle_queue and rrle_back; uses rrle_pkg.
//
// The decoder takes one encoded word per accepted input beat and emits one word
// per row segment of the expanded run. A parser in front decodes the escape
// sequences (0x80 0 for a literal 0x80, 0x80 N V for N+1 copies of V) into run
// commands held in a two-entry queue; the expander behind it walks each run one
// step per cycle unless the output register stalls an emit. A plain byte takes
// a fetch and an emit step; a run takes a fetch, an emit per row segment and a
// step per pad position of an odd-width row it crosses. Escape prefix bytes take
// no expander steps. The expander loop sets the throughput. The output register
// lets the next input word be taken while a segment waits.
// Registers: row_width at byte address 0 (reset 8), image_height at 4 (reset 1);
// write them only while the decoder is idle. After the last row, input is
// dropped until reset.
module raster_rle_byte_decoder import rrle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Encoded input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  // Segment output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [7:0] pixel_value, [16:8] run_length,
                                      // [32:17] row_index, [48:33] start_column
  output logic [1:0]  m_axis_tuser,   // [0] row_end, [1] image_end
  output logic        m_axis_tlast    // last segment of the input word
);

  cfg_t cfg_q;
  logic push, full, pop, cmd_valid;
  cmd_t push_cmd, pop_cmd;
  seg_t seg;
  logic cfg_wr;

  // Register writes and reads
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_width    <= MinWidth;
      cfg_q.image_height <= 16'd1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegRowWidth:    cfg_q.row_width    <= pwdata[15:0];
        RegImageHeight: cfg_q.image_height <= pwdata[15:0];
        default:        cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegRowWidth:    prdata = {16'd0, cfg_q.row_width};
      RegImageHeight: prdata = {16'd0, cfg_q.image_height};
      default:        prdata = 32'd0;
    endcase
  end

  rrle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .full_i     (full)
  );

  rrle_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (cmd_valid),
    .pop_cmd_o  (pop_cmd)
  );

  rrle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_seg_o   (seg)
  );

  // Output packing
  assign m_axis_tdata = {7'd0, seg.start_column, seg.row_index, seg.run_length,
                         seg.pixel_value};
  assign m_axis_tuser = {seg.image_end, seg.row_end};
  assign m_axis_tlast = seg.last;

endmodule

/* sv/rrle_checker.sv */
// Port-level checks for the raster RLE byte decoder, bound to its top level.
// Sees only the top-level ports; uses no package.
module rrle_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled segment word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("segment word changed while stalled");

  // Every segment covers at least one pixel and at most 256
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[16:8] != 9'd0) && (m_axis_tdata[16:8] <= 9'd256))
    else $error("segment length out of range");

  // End of image is also end of row and closes the word's segments
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0] && m_axis_tlast)
    else $error("image end without row end or last");

  // Nothing follows the end of the image
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser[1] |=> !m_axis_tvalid)
    else $error("segment after end of image");

endmodule

bind raster_rle_byte_decoder rrle_checker u_rrle_checker (.*);
